@@ design/dfs_maze_carver_core_defines.svh @@
// ----------------------------------------------------------------------------
// Maze carver assertion macros
// Concurrent check wrappers used by the maze carver RTL; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef DFS_MAZE_CARVER_CORE_DEFINES_SVH
`define DFS_MAZE_CARVER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every clock edge outside reset.
`define DFMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included.
`define DFMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DFMC_ASSERT(lbl, prop, msg)
`define DFMC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/dfmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Maze carver package
// Shared widths, codes, state encoding and helpers of the maze carver.
// ----------------------------------------------------------------------------
package dfmc_pkg;

  localparam int COORD_W      = 7;
  localparam int DEF_MAX_SIDE = 64;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 24;
  localparam int CFG_AW       = 1;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [CFG_AW-1:0] REG_COLS = 1'b0;
  localparam logic [CFG_AW-1:0] REG_ROWS = 1'b1;

  typedef enum logic [1:0] {
    DIR_E = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_N = 2'd3
  } dir_t;

  typedef struct packed {
    logic found;
    dir_t dir;
  } pick_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CHECK,
    ST_RD_N,
    ST_RD_S,
    ST_EVAL,
    ST_POP,
    ST_EMIT
  } state_t;

  // Clamp a side length or coordinate into 1..max_side.
  function automatic logic [COORD_W-1:0] clamp_side(input logic [COORD_W-1:0] v,
                                                    input int unsigned max_side);
    logic [COORD_W-1:0] r;
    if (v == '0) begin
      r = COORD_W'(1);
    end else if (32'(v) > max_side) begin
      r = COORD_W'(max_side);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ design/dfs_maze_carver_core.sv @@
// ----------------------------------------------------------------------------
// Maze carver core
// Randomized depth-first maze carving with a row-organized visited map and a
// path stack, both in synchronous memories with registered reads.
// ----------------------------------------------------------------------------
// One item is in work at a time. A step item whose current cell still has a
// free neighbour passes CHECK, RD_N, RD_S and EVAL (three visited-map row reads
// for the current, north and south rows, then the carve) and loads the result
// register in EMIT; the next item is taken once the block is back in IDLE.
// Every cell popped off the path stack while backtracking adds a POP state and
// a fresh read sequence, as the visited map has a single read port. A step
// after the maze is done goes from CHECK straight to EMIT. A begin item clears
// the visited map one row per cycle before its result loads. A stalled result
// holds the block and its input until it is taken.
// After reset the same clearing pass runs over every row before the first
// item is taken; configuration writes are taken at any time.
`include "dfs_maze_carver_core_defines.svh"

module dfs_maze_carver_core #(
  parameter int MAX_SIDE = dfmc_pkg::DEF_MAX_SIDE
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // start_x[6:0], start_y[13:7], rand_dir[15:14]
  input  logic [dfmc_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd[0]
  input  logic                            s_tuser,
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // from_x[6:0], from_y[13:7], carve_dir[15:14], carved[16], done_res[17], zero above
  output logic [dfmc_pkg::OUT_DATA_W-1:0] m_tdata,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dfmc_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [dfmc_pkg::COORD_W-1:0]    cfg_data
);
  import dfmc_pkg::*;

  localparam int ROW_AW = $clog2(MAX_SIDE);
  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int STK_AW = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int STK_W  = 2 * COORD_W;

  // --------------------------------------------------------------------------
  // Memories: visited map as one row of MAX_SIDE bits per word, and the path
  // stack of cell coordinates. Both have registered reads.
  // --------------------------------------------------------------------------
  logic [MAX_SIDE-1:0] vmap_mem [MAX_SIDE];
  logic [STK_W-1:0]    stack_mem [CELLS];

  logic                vm_re;
  logic [ROW_AW-1:0]   vm_raddr;
  logic                vm_we;
  logic [ROW_AW-1:0]   vm_waddr;
  logic [MAX_SIDE-1:0] vm_wdata;
  logic [MAX_SIDE-1:0] row_q;

  logic                stk_we;
  logic                stk_re;
  logic [STK_AW-1:0]   stk_waddr;
  logic [STK_AW-1:0]   stk_raddr;
  logic [STK_W-1:0]    stk_q;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state;
  state_t              state_next;

  logic [COORD_W-1:0]  cols;          // clamped at write time
  logic [COORD_W-1:0]  rows;
  logic [CNT_W-1:0]    total;         // cols * rows, registered from the size registers
  logic [STK_W-1:0]    area;

  logic [COORD_W-1:0]  cur_x;
  logic [COORD_W-1:0]  cur_y;
  logic [CNT_W-1:0]    depth;
  logic [CNT_W-1:0]    vcount;
  logic [ROW_AW-1:0]   clr_row;
  logic                mark_start;    // set the start cell during the clearing pass
  dir_t                pref;

  logic [MAX_SIDE-1:0] row_cur;
  logic [MAX_SIDE-1:0] row_n;

  logic [COORD_W-1:0]  res_x;
  logic [COORD_W-1:0]  res_y;
  dir_t                res_dir;
  logic                res_carved;

  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  dir_t                out_dir;
  logic                out_carved;
  logic                out_done;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic                in_accept;
  logic                begin_accept;
  logic [COORD_W-1:0]  sx_clamp;
  logic [COORD_W-1:0]  sy_clamp;
  logic [COORD_W-1:0]  sx;
  logic [COORD_W-1:0]  sy;
  logic                maze_done;
  logic                out_free;
  logic                last_row;

  logic [3:0]          free;
  pick_t               pick;
  logic [COORD_W-1:0]  tx;
  logic [COORD_W-1:0]  ty;
  logic [MAX_SIDE-1:0] tgt_row;
  logic                can_push;

  assign in_accept    = s_tvalid && s_tready;
  assign begin_accept = in_accept && (s_tuser == CMD_BEGIN);
  assign s_tready     = (state == ST_IDLE);
  assign cfg_ready    = 1'b1;

  // begin start cell: clamp into 1..MAX_SIDE, then into the grid
  assign sx_clamp = clamp_side(s_tdata[COORD_W-1:0], MAX_SIDE);
  assign sy_clamp = clamp_side(s_tdata[2*COORD_W-1:COORD_W], MAX_SIDE);
  assign sx       = (sx_clamp > cols) ? cols : sx_clamp;
  assign sy       = (sy_clamp > rows) ? rows : sy_clamp;

  assign area      = STK_W'(cols) * STK_W'(rows);
  assign maze_done = (vcount >= total);
  assign out_free  = !m_tvalid || m_tready;
  assign last_row  = (clr_row == ROW_AW'(MAX_SIDE - 1));
  assign can_push  = (depth < CNT_W'(CELLS));

  // Free neighbours: row_cur holds the current row, row_n the north row and
  // the read data in EVAL is the south row. Each bit test is guarded by its
  // bounds check, so an index past the grid is never used.
  always_comb begin
    free[DIR_E] = (cur_x < cols) && !row_cur[ROW_AW'(cur_x)];
    free[DIR_S] = (cur_y < rows) && !row_q[ROW_AW'(cur_x - 7'd1)];
    free[DIR_W] = (cur_x > 7'd1) && !row_cur[ROW_AW'(cur_x - 7'd2)];
    free[DIR_N] = (cur_y > 7'd1) && !row_n[ROW_AW'(cur_x - 7'd1)];
  end

  dfmc_dir_pick u_pick (
    .free (free),
    .pref (pref),
    .pick (pick)
  );

  // target cell and the row word it sits in
  always_comb begin
    tx      = cur_x;
    ty      = cur_y;
    tgt_row = row_cur;
    case (pick.dir)
      DIR_E: begin
        tx = cur_x + 7'd1;
      end
      DIR_S: begin
        ty      = cur_y + 7'd1;
        tgt_row = row_q;
      end
      DIR_W: begin
        tx = cur_x - 7'd1;
      end
      DIR_N: begin
        ty      = cur_y - 7'd1;
        tgt_row = row_n;
      end
      default: begin
        tx = cur_x;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (s_tuser == CMD_BEGIN) ? ST_CLEAR : ST_CHECK;
        end
      end
      ST_CLEAR: begin
        if (last_row) begin
          state_next = mark_start ? ST_EMIT : ST_IDLE;
        end
      end
      ST_CHECK: begin
        state_next = maze_done ? ST_EMIT : ST_RD_N;
      end
      ST_RD_N: begin
        state_next = ST_RD_S;
      end
      ST_RD_S: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (pick.found || depth == '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        state_next = ST_CHECK;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: memory controls. Reads and writes of the visited map fall in
  // different states, and every write lands before the next read sequence
  // starts, so no forwarding path is needed.
  // --------------------------------------------------------------------------
  always_comb begin
    vm_re     = 1'b0;
    vm_raddr  = '0;
    vm_we     = 1'b0;
    vm_waddr  = '0;
    vm_wdata  = '0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = depth[STK_AW-1:0];
    stk_raddr = STK_AW'(depth - CNT_W'(1));
    case (state)
      ST_CLEAR: begin
        vm_we    = 1'b1;
        vm_waddr = clr_row;
        if (mark_start && clr_row == ROW_AW'(cur_y - 7'd1)) begin
          vm_wdata = MAX_SIDE'(1) << ROW_AW'(cur_x - 7'd1);
        end
      end
      ST_CHECK: begin
        vm_re    = !maze_done;
        vm_raddr = ROW_AW'(cur_y - 7'd1);
      end
      ST_RD_N: begin
        vm_re    = 1'b1;
        vm_raddr = (cur_y > 7'd1) ? ROW_AW'(cur_y - 7'd2) : '0;
      end
      ST_RD_S: begin
        vm_re    = 1'b1;
        vm_raddr = (cur_y < rows) ? ROW_AW'(cur_y) : '0;
      end
      ST_EVAL: begin
        vm_we    = pick.found;
        vm_waddr = ROW_AW'(ty - 7'd1);
        vm_wdata = tgt_row | (MAX_SIDE'(1) << ROW_AW'(tx - 7'd1));
        stk_we   = pick.found && can_push;
        stk_re   = !pick.found && depth != '0;
      end
      default: begin
        vm_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmap_mem[vm_waddr] <= vm_wdata;
    end
    if (vm_re) begin
      row_q <= vmap_mem[vm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= {cur_y, cur_x};
    end
    if (stk_re) begin
      stk_q <= stack_mem[stk_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Datapath and control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cols       <= clamp_side(COORD_W'(DEF_MAX_SIDE), MAX_SIDE);
      rows       <= clamp_side(COORD_W'(DEF_MAX_SIDE), MAX_SIDE);
      cur_x      <= COORD_W'(1);
      cur_y      <= COORD_W'(1);
      depth      <= '0;
      vcount     <= '0;
      clr_row    <= '0;
      mark_start <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // configuration: store the clamped side length
      if (cfg_valid) begin
        case (cfg_addr)
          REG_COLS: cols <= clamp_side(cfg_data, MAX_SIDE);
          REG_ROWS: rows <= clamp_side(cfg_data, MAX_SIDE);
          default:  cols <= cols;
        endcase
      end

      // raise the result when the register loads, drop it once taken
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            pref <= dir_t'(s_tdata[IN_DATA_W-1:2*COORD_W]);
            if (s_tuser == CMD_BEGIN) begin
              mark_start <= 1'b1;
              clr_row    <= '0;
              cur_x      <= sx;
              cur_y      <= sy;
              depth      <= '0;
              vcount     <= CNT_W'(1);
              res_x      <= sx;
              res_y      <= sy;
              res_dir    <= DIR_E;
              res_carved <= 1'b0;
            end
          end
        end
        ST_CLEAR: begin
          clr_row <= clr_row + ROW_AW'(1);
        end
        ST_CHECK: begin
          if (maze_done) begin
            res_x      <= cur_x;
            res_y      <= cur_y;
            res_dir    <= DIR_E;
            res_carved <= 1'b0;
          end
        end
        ST_RD_N: begin
          row_cur <= row_q;
        end
        ST_RD_S: begin
          row_n <= row_q;
        end
        ST_EVAL: begin
          if (pick.found) begin
            // carve: push the old cell, advance into the target
            res_x      <= cur_x;
            res_y      <= cur_y;
            res_dir    <= pick.dir;
            res_carved <= 1'b1;
            cur_x      <= tx;
            cur_y      <= ty;
            vcount     <= vcount + CNT_W'(1);
            if (can_push) begin
              depth <= depth + CNT_W'(1);
            end
          end else if (depth != '0) begin
            // dead end: pop and retry from the previous cell
            depth <= depth - CNT_W'(1);
          end else begin
            res_x      <= cur_x;
            res_y      <= cur_y;
            res_dir    <= DIR_E;
            res_carved <= 1'b0;
          end
        end
        ST_POP: begin
          cur_x <= stk_q[COORD_W-1:0];
          cur_y <= stk_q[STK_W-1:COORD_W];
        end
        ST_EMIT: begin
          if (out_free) begin
            mark_start <= 1'b0;
          end
        end
        default: begin
          mark_start <= mark_start;
        end
      endcase
    end
  end

  // grid area, refreshed every cycle from the size registers
  always_ff @(posedge clk) begin
    total <= CNT_W'(area);
  end

  // result register: hold while the downstream side stalls
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_x      <= res_x;
      out_y      <= res_y;
      out_dir    <= res_dir;
      out_carved <= res_carved;
      out_done   <= maze_done;
    end
  end

  assign m_tdata = {(OUT_DATA_W - 2*COORD_W - 4)'(0), out_done, out_carved, out_dir,
                    out_y, out_x};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DFMC_ASSERT(a_stack_le_count, depth <= vcount, "path stack deeper than visited count")
  `DFMC_ASSERT(a_vmap_port_excl, !(vm_re && vm_we), "visited map read and write overlap")
  `DFMC_ASSERT(a_begin_clears, begin_accept |=> state == ST_CLEAR, "begin did not clear")

endmodule

@@ design/dfmc_dir_pick.sv @@
// ----------------------------------------------------------------------------
// Maze carver direction pick
// First free direction in rotation east, south, west, north from the preferred one.
// ----------------------------------------------------------------------------
module dfmc_dir_pick (
  input  logic [3:0]           free,
  input  dfmc_pkg::dir_t       pref,
  output dfmc_pkg::pick_t      pick
);
  import dfmc_pkg::*;

  always_comb begin
    dir_t d;
    pick.found = |free;
    pick.dir   = pref;
    // walk the rotation backward so the nearest free direction wins
    for (int k = 3; k >= 0; k--) begin
      d = dir_t'(pref + 2'(k));
      if (free[d]) begin
        pick.dir = d;
      end
    end
  end

endmodule

@@ tb/dfs_maze_carver_checker.sv @@
// ----------------------------------------------------------------------------
// Maze carver checker
// Watches the item, result and register channels of the maze carver, keeps
// its own copy of the maze state and compares every result item in order.
// ----------------------------------------------------------------------------
module dfs_maze_carver_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [dfmc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [dfmc_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dfmc_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [dfmc_pkg::COORD_W-1:0]    cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              carve_count,
  output int                              done_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfmc_pkg::*;

  localparam int SIDE  = DEF_MAX_SIDE;
  localparam int CELLS = SIDE * SIDE;

  // result item layout, lowest field last
  typedef struct packed {
    logic [5:0]         pad;
    logic               done;
    logic               carved;
    dir_t               dir;
    logic [COORD_W-1:0] fy;
    logic [COORD_W-1:0] fx;
  } carve_rec_t;

  logic               visited [CELLS];
  logic [COORD_W-1:0] trail_x [CELLS];
  logic [COORD_W-1:0] trail_y [CELLS];
  int                 trail_len;
  int                 nvisited;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [COORD_W-1:0] reg_cols;
  logic [COORD_W-1:0] reg_rows;
  carve_rec_t         carve_q [$];
  int                 errors;
  int                 carves;
  int                 dones;

  function automatic int grid_side(int v);
    if (v < 1) return 1;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  function automatic int cell_at(int x, int y);
    int i;
    i = (y - 1) * SIDE + (x - 1);
    return (i >= 0 && i < CELLS) ? i : 0;
  endfunction

  // Is the neighbor in direction d inside the grid and not yet visited?
  function automatic bit open_dir(dir_t d);
    int x;
    int y;
    x = cur_x;
    y = cur_y;
    case (d)
      DIR_E: begin
        if (x >= grid_side(reg_cols)) return 1'b0;
        x++;
      end
      DIR_S: begin
        if (y >= grid_side(reg_rows)) return 1'b0;
        y++;
      end
      DIR_W: begin
        if (x <= 1) return 1'b0;
        x--;
      end
      default: begin
        if (y <= 1) return 1'b0;
        y--;
      end
    endcase
    return !visited[cell_at(x, y)];
  endfunction

  function automatic bit any_open();
    return open_dir(DIR_E) || open_dir(DIR_S) || open_dir(DIR_W) || open_dir(DIR_N);
  endfunction

  function automatic void clear_maze();
    foreach (visited[i]) visited[i] = 1'b0;
    trail_len = 0;
    nvisited  = 0;
    cur_x     = COORD_W'(1);
    cur_y     = COORD_W'(1);
  endfunction

  function automatic carve_rec_t predict_carve(logic cmd, logic [COORD_W-1:0] sx,
                                               logic [COORD_W-1:0] sy, logic [1:0] pref);
    carve_rec_t rec;
    int         cols;
    int         rows;
    int         total;
    int         bx;
    int         by;
    dir_t       pick;
    cols  = grid_side(reg_cols);
    rows  = grid_side(reg_rows);
    total = cols * rows;
    rec   = '0;
    pick  = DIR_E;
    if (cmd == CMD_BEGIN) begin
      bx = grid_side(sx);
      by = grid_side(sy);
      if (bx > cols) bx = cols;
      if (by > rows) by = rows;
      clear_maze();
      cur_x = COORD_W'(bx);
      cur_y = COORD_W'(by);
      visited[cell_at(bx, by)] = 1'b1;
      nvisited = 1;
    end else if (nvisited < total) begin
      // backtrack until the current cell has somewhere to go
      while (!any_open() && trail_len > 0) begin
        trail_len--;
        cur_x = trail_x[trail_len];
        cur_y = trail_y[trail_len];
      end
      if (any_open()) begin
        for (int k = 3; k >= 0; k--) begin
          if (open_dir(dir_t'(2'(pref + k)))) pick = dir_t'(2'(pref + k));
        end
        rec.fx = cur_x;
        rec.fy = cur_y;
        rec.dir = pick;
        rec.carved = 1'b1;
        if (trail_len < CELLS) begin
          trail_x[trail_len] = cur_x;
          trail_y[trail_len] = cur_y;
          trail_len++;
        end
        case (pick)
          DIR_E:   cur_x++;
          DIR_S:   cur_y++;
          DIR_W:   cur_x--;
          default: cur_y--;
        endcase
        visited[cell_at(cur_x, cur_y)] = 1'b1;
        nvisited++;
        rec.done = (nvisited >= total);
        return rec;
      end
    end
    rec.fx   = cur_x;
    rec.fy   = cur_y;
    rec.done = (nvisited >= total);
    return rec;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    carve_rec_t want;
    carve_rec_t got;
    if (rst) begin
      clear_maze();
      reg_cols = COORD_W'(64);
      reg_rows = COORD_W'(64);
      carve_q.delete();
      errors = 0;
      carves = 0;
      dones  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == REG_COLS) reg_cols = cfg_data;
        else reg_rows = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got = carve_rec_t'(m_tdata);
        if (carve_q.size() == 0) begin
          $error("result item 0x%h with no item outstanding", m_tdata);
          errors++;
        end else begin
          want = carve_q.pop_front();
          check_field("from_x", want.fx, got.fx);
          check_field("from_y", want.fy, got.fy);
          check_field("carve_dir", want.dir, got.dir);
          check_field("carved", want.carved, got.carved);
          check_field("done_res", want.done, got.done);
          check_field("padding", want.pad, got.pad);
          carves += want.carved;
          dones  += want.done;
        end
      end
      if (s_tvalid && s_tready) begin
        carve_q.push_back(predict_carve(s_tuser, s_tdata[6:0], s_tdata[13:7],
                                        s_tdata[15:14]));
      end
    end
    fail_count  <= errors;
    pending     <= carve_q.size();
    carve_count <= carves;
    done_count  <= dones;
  end

endmodule

@@ tb/dfs_maze_carver_core_test.sv @@
// ----------------------------------------------------------------------------
// Maze carver testbench
// Drives begin and step items through the maze carver under random stalls,
// resizes the grid between and within mazes and leaves the checking to the checker.
// ----------------------------------------------------------------------------
module dfs_maze_carver_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dfmc_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int STALL_LIMIT = 20000;  // cycles with no handshake on any channel
  localparam int LONG_HOLD   = 400;    // receiver hold-off that backs up the input
  localparam int DRAIN_WAIT  = 100;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // start_x[6:0], start_y[13:7], rand_dir[15:14]
  logic [IN_DATA_W-1:0]  s_tdata;
  // cmd[0]
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // from_x[6:0], from_y[13:7], carve_dir[15:14], carved[16], done_res[17], zero above
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [COORD_W-1:0]    cfg_data;

  int fail_count;
  int pending;
  int carve_count;
  int done_count;
  int items_sent;
  int phases;
  int idle_cycles;
  int hold_left;
  bit long_hold_done;
  bit calm;  // stretch with no idling on either side

  dfs_maze_carver_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  dfs_maze_carver_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .carve_count (carve_count),
    .done_count  (done_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, none at all in a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int grid_side(int v);
    if (v < 1) return 1;
    if (v > DEF_MAX_SIDE) return DEF_MAX_SIDE;
    return v;
  endfunction

  // Offer one item after a random gap; leave tvalid high so the next item can
  // follow back to back.
  task automatic send_item(logic cmd, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                           logic [1:0] pref);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {pref, sy, sx};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Step items carry junk in the start fields; the block must ignore it.
  task automatic step(logic [1:0] pref);
    send_item(CMD_STEP, COORD_W'($urandom_range(0, 127)), COORD_W'($urandom_range(0, 127)),
              pref);
  endtask

  // Stop offering and wait until every outstanding result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write both grid registers once every outstanding result has been taken.
  task automatic set_grid(logic [COORD_W-1:0] cols, logic [COORD_W-1:0] rows);
    drain();
    cfg_valid <= 1'b1;
    cfg_addr  <= REG_COLS;
    cfg_data  <= cols;
    do @(posedge clk); while (!cfg_ready);
    cfg_addr  <= REG_ROWS;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random hold-offs, plus one long hold once traffic is flowing so
  // the block fills up and stalls its input while the sender keeps offering.
  initial begin
    m_tready <= 1'b0;
    hold_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && items_sent >= 600) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else begin
        hold_left = pick_gap();
        if (hold_left > 0) begin
          hold_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= CMD_STEP;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_addr  <= REG_COLS;
    cfg_data  <= '0;
    calm = 1'b0;
    items_sent = 0;
    phases = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Single-cell grid before any begin: nothing to carve and nothing to pop.
    set_grid(7'd1, 7'd1);
    step(DIR_N);
    // Widen to two cells: the first steps carve from an unmarked (1,1) and then
    // walk straight back into it.
    set_grid(7'd2, 7'd1);
    step(DIR_W);
    step(DIR_E);
    // Start clamps to the grid; the following step carves the remaining cell.
    send_item(CMD_BEGIN, 7'd127, 7'd127, DIR_E);
    step(DIR_S);
    // Out-of-range register values: 127 columns and zero rows.
    set_grid(7'd127, 7'd0);
    send_item(CMD_BEGIN, 7'd0, 7'd0, DIR_N);
    step(DIR_S);
    // Full-size grid, start in the far corner so east and south are blocked.
    set_grid(7'd64, 7'd64);
    send_item(CMD_BEGIN, 7'd127, 7'd127, DIR_W);
    step(DIR_E);
    step(DIR_S);
    step(DIR_W);
    step(DIR_N);
    // Two by two: carve it out and step past completion.
    set_grid(7'd2, 7'd2);
    send_item(CMD_BEGIN, 7'd2, 7'd1, DIR_S);
    step(DIR_E);
    step(DIR_S);
    step(DIR_W);
    step(DIR_N);
    // Resize in the middle of a maze.
    set_grid(7'd3, 7'd3);
    send_item(CMD_BEGIN, 7'd2, 7'd2, DIR_E);
    step(DIR_N);
    step(DIR_W);
    set_grid(7'd5, 7'd4);
    step(DIR_S);
    step(DIR_E);
    step(DIR_N);

    // Random mazes: mostly small grids carved to completion, a few large ones
    // carved part way, the odd restart and the odd resize halfway through.
    while (items_sent < ITEM_TARGET) begin : maze_phase
      int kind;
      int c;
      int r;
      int sx;
      int sy;
      int steps;
      int budget;
      bit reshape;
      calm = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        c = $urandom_range(32, 64);
        r = $urandom_range(32, 64);
        budget = $urandom_range(60, 250);
      end else if (kind == 1) begin
        c = $urandom_range(0, 1) ? 0 : 127;
        r = ($urandom_range(0, 3) == 0) ? 127 : $urandom_range(0, 4);
        budget = 60;
      end else begin
        c = $urandom_range(1, 8);
        r = $urandom_range(1, 8);
        budget = 1000;
      end
      steps = grid_side(c) * grid_side(r) - 1 + $urandom_range(0, 3);
      if (steps > budget) steps = budget;
      if ($urandom_range(0, 4) == 0) begin
        sx = $urandom_range(0, 127);
        sy = $urandom_range(0, 127);
      end else begin
        sx = $urandom_range(1, grid_side(c));
        sy = $urandom_range(1, grid_side(r));
      end
      reshape = ($urandom_range(0, 7) == 0);
      set_grid(COORD_W'(c), COORD_W'(r));
      send_item(CMD_BEGIN, COORD_W'(sx), COORD_W'(sy), 2'($urandom()));
      for (int i = 0; i < steps; i++) begin
        if (reshape && i == steps / 2) begin
          set_grid(COORD_W'($urandom_range(1, 8)), COORD_W'($urandom_range(1, 8)));
        end
        if ($urandom_range(0, 59) == 0) begin
          send_item(CMD_BEGIN, COORD_W'($urandom_range(0, 127)),
                    COORD_W'($urandom_range(0, 127)), 2'($urandom()));
        end else begin
          step(2'($urandom()));
        end
      end
      phases++;
    end

    calm = 1'b0;
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Ran %0d random mazes after the directed cases: %0d items in total,",
             phases, items_sent);
    $display("%0d passages carved and %0d results reporting a finished maze.",
             carve_count, done_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/dfmc_pkg.sv
design/dfmc_dir_pick.sv
design/dfs_maze_carver_core.sv
tb/dfs_maze_carver_checker.sv
tb/dfs_maze_carver_core_test.sv
